// ----- rtl/mmq_pkg.sv -----
// Shared command, status and mode codes and default sizes of the mailbox message queue.
package mmq_pkg;

	localparam int CMD_W    = 2;
	localparam int BOX_ID_W = 10;
	localparam int MODE_W   = 2;
	localparam int WORD_W   = 64;
	localparam int STATUS_W = 2;

	localparam int NUM_BOXES_DEF   = 1024;
	localparam int QUEUE_DEPTH_DEF = 3;
	localparam int MSG_WIDTH_DEF   = 64;

	localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SEND     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RECEIVE  = 2'd2;

	localparam logic [MODE_W-1:0] MODE_UNQUEUED = 2'd0;
	localparam logic [MODE_W-1:0] MODE_QUEUED   = 2'd1;

	localparam logic [STATUS_W-1:0] ST_FAIL = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MSG  = 2'd2;

endpackage

// ----- rtl/mailbox_message_queue.sv -----
// Top level of the mailbox message queue: command sequencer, clearing pass and result register.
// Each command first reads the box entry and message row, then updates them.
// A new word is accepted only while idle, so the next word waits until the current command has finished.
// The result enters the output register with the update, once that register is empty or being read.
// After reset a clearing pass zeroes every box entry in turn; no word is accepted then.
// Reset clears the control state; message slots are unknown until written.
module mailbox_message_queue #(
	parameter int NUM_BOXES   = mmq_pkg::NUM_BOXES_DEF,
	parameter int QUEUE_DEPTH = mmq_pkg::QUEUE_DEPTH_DEF,
	parameter int MSG_WIDTH   = mmq_pkg::MSG_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mmq_pkg::CMD_W-1:0]     command,
	input  logic [mmq_pkg::BOX_ID_W-1:0]  box_id,
	input  logic [mmq_pkg::MODE_W-1:0]    mailbox_mode,
	input  logic [mmq_pkg::WORD_W-1:0]    message_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mmq_pkg::STATUS_W-1:0]  status,
	output logic [mmq_pkg::WORD_W-1:0]    message_out
);

	localparam int AW  = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
	localparam int HW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int SW  = CW + 1;
	localparam int EW  = 2 + CW + HW;
	localparam int IDW = mmq_pkg::BOX_ID_W;
	localparam int XW  = IDW + AW;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic                  state_q;
	logic                  clr_q;
	logic [AW-1:0]         clr_addr_q;

	logic [mmq_pkg::CMD_W-1:0]  cmd_s1;
	logic [AW-1:0]              idx_s1;
	logic                       in_range_s1;
	logic [mmq_pkg::MODE_W-1:0] mode_s1;
	logic [MSG_WIDTH-1:0]       msg_s1;

	logic                          out_valid_q;
	logic [mmq_pkg::STATUS_W-1:0]  status_q;
	logic [mmq_pkg::WORD_W-1:0]    message_q;

	logic [XW-1:0]   id_ext;
	logic [AW-1:0]   in_idx;
	logic            in_range;
	logic            accept;
	logic            go;

	logic [EW-1:0]   rd_entry;
	logic            rd_reg;
	logic            rd_qm;
	logic [CW-1:0]   rd_cnt;
	logic [HW-1:0]   rd_head;
	logic [QUEUE_DEPTH-1:0][MSG_WIDTH-1:0] rd_row;

	logic            new_reg;
	logic            new_qm;
	logic [CW-1:0]   new_cnt;
	logic [HW-1:0]   new_head;
	logic            box_upd;
	logic            msg_upd;
	logic [HW-1:0]   wr_slot;
	logic [SW-1:0]   tail_sum;
	logic [SW-1:0]   head_inc;
	logic [mmq_pkg::STATUS_W-1:0] res_status;
	logic [MSG_WIDTH-1:0]         res_msg;

	logic            box_we;
	logic [AW-1:0]   box_waddr;
	logic [EW-1:0]   box_wdata;

	assign id_ext   = {{AW{1'b0}}, box_id};
	assign in_idx   = id_ext[AW-1:0];
	assign in_range = (id_ext < XW'(NUM_BOXES));
	assign in_ready = (state_q == ST_IDLE) && !clr_q;
	assign accept   = in_valid && in_ready;
	assign go       = (state_q == ST_EXEC) && (!out_valid_q || out_ready);

	assign {rd_reg, rd_qm, rd_cnt, rd_head} = rd_entry;

	always_comb begin
		new_reg    = rd_reg;
		new_qm     = rd_qm;
		new_cnt    = rd_cnt;
		new_head   = rd_head;
		box_upd    = 1'b0;
		msg_upd    = 1'b0;
		res_status = mmq_pkg::ST_FAIL;
		res_msg    = '0;
		tail_sum   = SW'(rd_head) + SW'(rd_cnt);
		if (tail_sum >= SW'(QUEUE_DEPTH)) begin
			tail_sum = tail_sum - SW'(QUEUE_DEPTH);
		end
		head_inc = SW'(rd_head) + SW'(1);
		if (head_inc == SW'(QUEUE_DEPTH)) begin
			head_inc = '0;
		end
		wr_slot = rd_head;
		if (in_range_s1) begin
			case (cmd_s1)
				mmq_pkg::CMD_REGISTER: begin
					if (!rd_reg && (mode_s1 == mmq_pkg::MODE_UNQUEUED ||
							mode_s1 == mmq_pkg::MODE_QUEUED)) begin
						new_reg    = 1'b1;
						new_qm     = (mode_s1 == mmq_pkg::MODE_QUEUED);
						new_cnt    = '0;
						new_head   = '0;
						box_upd    = 1'b1;
						res_status = mmq_pkg::ST_OK;
					end
				end
				mmq_pkg::CMD_SEND: begin
					if (rd_reg) begin
						if (!rd_qm) begin
							new_cnt    = CW'(1);
							box_upd    = 1'b1;
							msg_upd    = 1'b1;
							res_status = mmq_pkg::ST_OK;
						end else if (rd_cnt < CW'(QUEUE_DEPTH)) begin
							wr_slot    = tail_sum[HW-1:0];
							new_cnt    = rd_cnt + CW'(1);
							box_upd    = 1'b1;
							msg_upd    = 1'b1;
							res_status = mmq_pkg::ST_OK;
						end
					end
				end
				mmq_pkg::CMD_RECEIVE: begin
					if (rd_reg && rd_cnt != '0) begin
						res_msg    = rd_row[rd_head];
						new_head   = head_inc[HW-1:0];
						new_cnt    = rd_cnt - CW'(1);
						box_upd    = 1'b1;
						res_status = mmq_pkg::ST_MSG;
					end
				end
				default: begin
					res_status = mmq_pkg::ST_FAIL;
				end
			endcase
		end
	end

	always_comb begin
		if (clr_q) begin
			box_we    = 1'b1;
			box_waddr = clr_addr_q;
			box_wdata = '0;
		end else begin
			box_we    = go && box_upd;
			box_waddr = idx_s1;
			box_wdata = {new_reg, new_qm, new_cnt, new_head};
		end
	end

	mmq_box_ram #(
		.DEPTH (NUM_BOXES),
		.WIDTH (EW),
		.AW    (AW)
	) u_box_ram (
		.clk   (clk),
		.we    (box_we),
		.waddr (box_waddr),
		.wdata (box_wdata),
		.re    (accept),
		.raddr (in_idx),
		.rdata (rd_entry)
	);

	mmq_msg_ram #(
		.NUM_BOXES   (NUM_BOXES),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.MSG_WIDTH   (MSG_WIDTH),
		.AW          (AW),
		.HW          (HW)
	) u_msg_ram (
		.clk   (clk),
		.we    (go && msg_upd),
		.waddr (idx_s1),
		.wslot (wr_slot),
		.wdata (msg_s1),
		.re    (accept),
		.raddr (in_idx),
		.rdata (rd_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(NUM_BOXES - 1)) begin
					clr_q <= 1'b0;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= command;
			idx_s1      <= in_idx;
			in_range_s1 <= in_range;
			mode_s1     <= mailbox_mode;
			msg_s1      <= message_word[MSG_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			status_q  <= res_status;
			message_q <= mmq_pkg::WORD_W'(res_msg);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign message_out = message_q;

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !in_ready)
		else $error("Word accepted during the clearing pass.");

	a_deliver_only_on_receive: assert property (@(posedge clk) disable iff (!arst_n)
		(go && res_status == mmq_pkg::ST_MSG) |-> (cmd_s1 == mmq_pkg::CMD_RECEIVE))
		else $error("Message delivered for a command other than receive.");

	a_fill_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && rd_reg) |-> (rd_cnt <= CW'(QUEUE_DEPTH)))
		else $error("Box fill count exceeds the queue depth.");

	a_message_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != mmq_pkg::ST_MSG) |-> (message_out == '0))
		else $error("Message output is not zero without a delivered message.");

	a_exec_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> (out_valid && state_q == ST_IDLE))
		else $error("Command finished without a result in the output register.");

endmodule

// ----- rtl/mmq_box_ram.sv -----
// Synchronous single-write, single-read memory that holds the per-box control entries.
module mmq_box_ram #(
	parameter int DEPTH = mmq_pkg::NUM_BOXES_DEF,
	parameter int WIDTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/mmq_msg_ram.sv -----
// Message memory with one row of slots per box, written one slot at a time and read a row at a time.
module mmq_msg_ram #(
	parameter int NUM_BOXES   = mmq_pkg::NUM_BOXES_DEF,
	parameter int QUEUE_DEPTH = mmq_pkg::QUEUE_DEPTH_DEF,
	parameter int MSG_WIDTH   = mmq_pkg::MSG_WIDTH_DEF,
	parameter int AW          = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1,
	parameter int HW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [AW-1:0]                         waddr,
	input  logic [HW-1:0]                         wslot,
	input  logic [MSG_WIDTH-1:0]                  wdata,
	input  logic                                  re,
	input  logic [AW-1:0]                         raddr,
	output logic [QUEUE_DEPTH-1:0][MSG_WIDTH-1:0] rdata
);

	logic [QUEUE_DEPTH-1:0][MSG_WIDTH-1:0] mem [NUM_BOXES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr][wslot] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
